@@ design/llgu_pkg.sv @@
package llgu_pkg;

    // Fixed-point format and line buffer geometry.
    localparam int FRAC_BITS = 20;
    localparam int MAX_COLS  = 2048;
    localparam int LINE_BITS = FRAC_BITS + 10;
    localparam int LINE_DEPTH = 2 * MAX_COLS;
    localparam int ADDR_W    = $clog2(LINE_DEPTH);
    localparam int COLPOS_W  = $clog2(MAX_COLS);
    localparam int CALC_W    = 36;

    // Register indexes on the configuration port.
    localparam logic REG_COL_COUNT = 1'b0;
    localparam logic REG_SCAN_ROWS = 1'b1;

    // Degree constants at the scales in use.
    localparam logic signed [CALC_W-1:0] D90_Q20  = CALC_W'(64'sd90  <<< FRAC_BITS);
    localparam logic signed [CALC_W-1:0] D360_Q20 = CALC_W'(64'sd360 <<< FRAC_BITS);
    localparam logic signed [CALC_W-1:0] D90_Q21  = CALC_W'(64'sd90  <<< (FRAC_BITS + 1));
    localparam logic signed [CALC_W-1:0] D180_Q21 = CALC_W'(64'sd180 <<< (FRAC_BITS + 1));
    localparam logic signed [CALC_W-1:0] D360_Q21 = CALC_W'(64'sd360 <<< (FRAC_BITS + 1));
    localparam logic signed [CALC_W-1:0] D180_Q23 = CALC_W'(64'sd180 <<< (FRAC_BITS + 3));
    localparam logic signed [CALC_W-1:0] D360_Q23 = CALC_W'(64'sd360 <<< (FRAC_BITS + 3));

    // One half-step sample handed to the fine-row emitter.
    typedef struct packed {
        logic [ADDR_W-1:0]           col;
        logic signed [LINE_BITS-1:0] w_lat;
        logic signed [LINE_BITS-1:0] w_lon;
        logic [8:0]                  row_base;
        logic [1:0]                  j_first;
        logic [1:0]                  j_last;
        logic                        last;
    } half_t;

endpackage

@@ design/llgu_line_ram.sv @@
module llgu_line_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first single port: the old entry is returned while the new one is written.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ design/llgu_fine.sv @@
module llgu_fine
    import llgu_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        hs_valid,
    input  half_t                       hs,
    output logic                        hs_ready,
    input  logic signed [LINE_BITS-1:0] u_lat,
    input  logic signed [LINE_BITS-1:0] u_lon,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [8:0]                  m_out_row_in_scan,
    output logic [11:0]                 m_out_col,
    output logic signed [29:0]          m_lat_out,
    output logic signed [28:0]          m_lon_out,
    output logic                        m_last
);

    logic        busy_reg;
    half_t       h_reg;
    logic [1:0]  j_reg;
    logic        m_valid_reg;
    logic        emit;
    logic        done;
    logic        u_load_reg;
    logic signed [LINE_BITS-1:0] u_lat_reg, u_lon_reg, u_lat_cur, u_lon_cur;

    logic signed [CALC_W-1:0] ul, wl, un, wn, lat_sum, lon_sum, lon_wr;
    logic signed [CALC_W-1:0] lat_rnd, lon_rnd;

    assign emit     = busy_reg && (!m_valid_reg || m_ready);
    assign done     = emit && (j_reg == h_reg.j_last);
    assign hs_ready = !busy_reg || done;
    assign m_valid  = m_valid_reg;

    // The line buffer data is valid only in the cycle after the request; hold it from then on.
    assign u_lat_cur = u_load_reg ? u_lat : u_lat_reg;
    assign u_lon_cur = u_load_reg ? u_lon : u_lon_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_load_reg <= 1'b0;
        end else begin
            u_load_reg <= hs_valid && hs_ready;
        end
        if (u_load_reg) begin
            u_lat_reg <= u_lat;
            u_lon_reg <= u_lon;
        end
    end

    // Weighted sum of the upper and lower half-step values in Q23.
    always_comb begin
        ul = CALC_W'(u_lat_cur);
        wl = CALC_W'(h_reg.w_lat);
        un = CALC_W'(u_lon_cur);
        wn = CALC_W'(h_reg.w_lon);
        if (un > D90_Q21 && wn < -D90_Q21) begin
            wn = wn + D360_Q21;
        end else if (un < -D90_Q21 && wn > D90_Q21) begin
            un = un + D360_Q21;
        end
        unique case (j_reg)
            2'd0: begin
                lat_sum = (ul <<< 2) + ul - wl;
                lon_sum = (un <<< 2) + un - wn;
            end
            2'd1: begin
                lat_sum = (ul <<< 1) + ul + wl;
                lon_sum = (un <<< 1) + un + wn;
            end
            2'd2: begin
                lat_sum = ul + (wl <<< 1) + wl;
                lon_sum = un + (wn <<< 1) + wn;
            end
            default: begin
                lat_sum = (wl <<< 2) + wl - ul;
                lon_sum = (wn <<< 2) + wn - un;
            end
        endcase
        if (lon_sum > D180_Q23) begin
            lon_wr = lon_sum - D360_Q23;
        end else if (lon_sum < -D180_Q23) begin
            lon_wr = lon_sum + D360_Q23;
        end else begin
            lon_wr = lon_sum;
        end
        // Round to nearest, ties upwards.
        lat_rnd = (lat_sum + CALC_W'(4)) >>> 3;
        lon_rnd = (lon_wr + CALC_W'(4)) >>> 3;
    end

    // Sequencing of fine rows for the held half-step sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (hs_valid && hs_ready) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
        if (hs_valid && hs_ready) begin
            h_reg <= hs;
            j_reg <= hs.j_first;
        end else if (emit) begin
            j_reg <= j_reg + 2'd1;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (emit) begin
            m_out_row_in_scan <= h_reg.row_base + 9'(j_reg);
            m_out_col         <= h_reg.col;
            m_lat_out         <= lat_rnd[29:0];
            m_lon_out         <= lon_rnd[28:0];
            m_last            <= h_reg.last && (j_reg == h_reg.j_last);
        end
    end

`ifndef NO_ASSERTIONS
    a_hs_only_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        hs_valid |-> hs_ready) else $error("half sample offered while emitter busy");
    a_j_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> j_reg <= h_reg.j_last) else $error("fine row past its end");
    a_done_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        done && !hs_valid |=> !busy_reg) else $error("emitter did not free");
`endif

endmodule

@@ design/latlon_grid_upsample_2x_planar_top.sv @@
// Channel   Direction  Handshake           Payload
// apb       in/out     psel/penable/pready col_count (0x0), scan_rows (0x4)
// s_        in         s_valid/s_ready     s_lat_in, s_lon_in
// m_        out        m_valid/m_ready     row, col, lat, lon, last
// Each coarse pixel becomes 0, 2 or 4 half-step samples, one a cycle through the
// single-port line buffer; each half-step sample gives 0, 2, 3 or 4 fine results, one a
// cycle from the output register. Sustained rate is one result a cycle, about four per pixel.
// Reset sets default sizes and clears counters and valid flags; line RAM needs no clearing.
// A stalled result channel holds the emitter, which in turn holds the half-step issue.
module latlon_grid_upsample_2x_planar_top
    import llgu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [27:0]   s_lat_in,
    input  logic signed [28:0]   s_lon_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [8:0]           m_out_row_in_scan,
    output logic [11:0]          m_out_col,
    output logic signed [29:0]   m_lat_out,
    output logic signed [28:0]   m_lon_out,
    output logic                 m_last
);

    logic [11:0] col_count_reg;
    logic [7:0]  scan_rows_reg;
    logic [COLPOS_W-1:0] col_pos_reg;
    logic [7:0]  row_reg;
    logic signed [27:0] prev_lat_reg;
    logic signed [28:0] prev_lon_reg;

    logic signed [27:0] px_a_reg, px_p_reg;
    logic signed [28:0] px_b_reg, px_q_reg;
    logic [COLPOS_W-1:0] px_c_reg;
    logic [7:0]  px_r_reg;
    logic [2:0]  nh_reg, hi_reg;

    logic        cfg_we;
    logic [11:0] cols;
    logic [7:0]  rows;
    logic [COLPOS_W-1:0] cur_c;
    logic [7:0]  cur_r;
    logic        cur_lastcol;
    logic        accept;
    logic        pending, issue, issue_last, hs_ready, hs_valid;
    half_t       hs;

    logic signed [CALC_W-1:0] a, b, p, q, hl, hn, hw;
    logic [ADDR_W-1:0] s_col;
    logic [2*LINE_BITS-1:0] rdata;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    always_comb begin
        unique case (paddr[2])
            REG_COL_COUNT: prdata = 32'(col_count_reg);
            default:       prdata = 32'(scan_rows_reg);
        endcase
    end

    // Effective geometry and the position of the next pixel.
    assign cols = (col_count_reg < 12'd2) ? 12'd2 :
                  (col_count_reg > 12'(MAX_COLS)) ? 12'(MAX_COLS) : col_count_reg;
    assign rows = (scan_rows_reg < 8'd2) ? 8'd2 : scan_rows_reg;
    assign cur_c = (12'(col_pos_reg) >= cols) ? '0 : col_pos_reg;
    assign cur_r = (row_reg >= rows) ? 8'd0 : row_reg;
    assign cur_lastcol = (12'(cur_c) == cols - 12'd1);

    // Half-step issue control.
    assign pending    = hi_reg < nh_reg;
    assign issue      = pending && ((px_r_reg == 8'd0) || hs_ready);
    assign issue_last = issue && (hi_reg == nh_reg - 3'd1);
    assign s_ready    = !pending || issue_last;
    assign accept     = s_valid && s_ready;
    assign hs_valid   = issue && (px_r_reg != 8'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= 12'd1354;
            scan_rows_reg <= 8'd10;
            col_pos_reg   <= '0;
            row_reg       <= '0;
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
            nh_reg        <= '0;
            hi_reg        <= '0;
        end else begin
            if (cfg_we) begin
                if (paddr[2] == REG_COL_COUNT) begin
                    col_count_reg <= pwdata[11:0];
                end else begin
                    scan_rows_reg <= pwdata[7:0];
                end
                col_pos_reg <= '0;
                row_reg     <= '0;
            end else if (accept) begin
                if (cur_lastcol) begin
                    col_pos_reg <= '0;
                    row_reg     <= (cur_r + 8'd1 >= rows) ? 8'd0 : cur_r + 8'd1;
                end else begin
                    col_pos_reg <= cur_c + 1'b1;
                    row_reg     <= cur_r;
                end
            end
            if (accept) begin
                prev_lat_reg <= s_lat_in;
                prev_lon_reg <= s_lon_in;
                hi_reg       <= '0;
                nh_reg       <= (cur_c == '0) ? 3'd0 : (cur_lastcol ? 3'd4 : 3'd2);
            end else if (issue) begin
                hi_reg <= hi_reg + 3'd1;
            end
        end
    end

    // Pixel under work.
    always_ff @(posedge aclk) begin
        if (accept) begin
            px_a_reg <= s_lat_in;
            px_b_reg <= s_lon_in;
            px_p_reg <= prev_lat_reg;
            px_q_reg <= prev_lon_reg;
            px_c_reg <= cur_c;
            px_r_reg <= cur_r;
        end
    end

    // Half-step value for the current index, with the date-line rules.
    always_comb begin
        a = CALC_W'(px_a_reg);
        b = CALC_W'(px_b_reg);
        p = CALC_W'(px_p_reg);
        q = CALC_W'(px_q_reg);
        unique case (hi_reg[1:0])
            2'd0: begin
                hl = p <<< 1;
                hn = q <<< 1;
            end
            2'd1: begin
                hl = p + a;
                hn = q + b;
                if ((q > D90_Q20 && b < -D90_Q20) || (q < -D90_Q20 && b > D90_Q20)) begin
                    hn = hn + D360_Q20;
                end
            end
            2'd2: begin
                hl = a <<< 1;
                hn = b <<< 1;
            end
            default: begin
                hl = (a <<< 1) + a - p;
                if (b > D90_Q20 && q < -D90_Q20) begin
                    hn = (b <<< 1) + b - (q + D360_Q20);
                end else if (b < -D90_Q20 && q > D90_Q20) begin
                    hn = ((b + D360_Q20) <<< 1) + (b + D360_Q20) - q;
                end else begin
                    hn = (b <<< 1) + b - q;
                end
            end
        endcase
        if (hn > D180_Q21) begin
            hw = hn - D360_Q21;
        end else if (hn < -D180_Q21) begin
            hw = hn + D360_Q21;
        end else begin
            hw = hn;
        end
        s_col = ADDR_W'({px_c_reg, 1'b0}) + ADDR_W'(hi_reg) - ADDR_W'(2);
    end

    // Descriptor for the fine-row emitter.
    always_comb begin
        hs.col      = s_col;
        hs.w_lat    = hl[LINE_BITS-1:0];
        hs.w_lon    = hw[LINE_BITS-1:0];
        hs.row_base = {px_r_reg, 1'b0} - 9'd2;
        hs.j_first  = (px_r_reg == 8'd1) ? 2'd0 : 2'd1;
        hs.j_last   = (px_r_reg == rows - 8'd1) ? 2'd3 : 2'd2;
        hs.last     = (hi_reg == nh_reg - 3'd1);
    end

    llgu_line_ram #(
        .WIDTH(2 * LINE_BITS),
        .DEPTH(LINE_DEPTH),
        .AW   (ADDR_W)
    ) u_line_ram (
        .aclk (aclk),
        .we   (issue),
        .addr (s_col),
        .wdata({hl[LINE_BITS-1:0], hw[LINE_BITS-1:0]}),
        .rdata(rdata)
    );

    llgu_fine u_fine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .hs_valid         (hs_valid),
        .hs               (hs),
        .hs_ready         (hs_ready),
        .u_lat            (rdata[2*LINE_BITS-1:LINE_BITS]),
        .u_lon            (rdata[LINE_BITS-1:0]),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_row_in_scan(m_out_row_in_scan),
        .m_out_col        (m_out_col),
        .m_lat_out        (m_lat_out),
        .m_lon_out        (m_lon_out),
        .m_last           (m_last)
    );

`ifndef NO_ASSERTIONS
    a_hi_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        hi_reg <= nh_reg) else $error("half-step index beyond its count");
    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !pending || issue_last) else $error("request taken over pending work");
    a_nh_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        nh_reg == 3'd0 || nh_reg == 3'd2 || nh_reg == 3'd4) else $error("bad half-step count");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import llgu_pkg::*;

    localparam int    LONG_HOLD  = 300;
    localparam int    IDLE_LIMIT = 5000;
    localparam int    DRAIN_WAIT = 40;
    localparam longint LAT_MAX   = 94371840;
    localparam longint LON_MAX   = 188743680;

    typedef struct {
        logic signed [27:0] lat;
        logic signed [28:0] lon;
    } pixel_t;

    typedef struct {
        logic [8:0]  row;
        logic [11:0] col;
        logic [29:0] lat;
        logic [28:0] lon;
        logic        last;
    } fine_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic signed [27:0]  s_lat_in = '0;
    logic signed [28:0]  s_lon_in = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [8:0]          m_out_row_in_scan;
    logic [11:0]         m_out_col;
    logic signed [29:0]  m_lat_out;
    logic signed [28:0]  m_lon_out;
    logic                m_last;

    latlon_grid_upsample_2x_planar_top u_top (.*);

    // Clock.
    always #5 aclk = ~aclk;

    pixel_t pending_pixels[$];
    fine_t  expected_fine[$];
    int     mismatches = 0;
    bit     hold_req = 1'b0;

    // Shadow state of the upsampler.
    longint cfg_cols = 1354;
    longint cfg_rows = 10;
    longint last_lat = 0;
    longint last_lon = 0;
    longint half_lat[4096];
    longint half_lon[4096];
    int     pix_col = 0;
    int     pix_row = 0;

    function automatic longint sx(longint v, int bits);
        return (v <<< (64 - bits)) >>> (64 - bits);
    endfunction

    function automatic longint wrap_lon(longint v, int fb);
        longint d180;
        d180 = longint'(180) <<< fb;
        if (v > d180) return v - 2 * d180;
        if (v < -d180) return v + 2 * d180;
        return v;
    endfunction

    // Quarter-weighted blend of two half-step values into one fine sample.
    function automatic void blend_fine(int row, int col, longint ulat, longint wlat,
                                       longint ulon, longint wlon, longint cu, longint cw);
        longint d90;
        longint lat;
        longint lon;
        fine_t  f;
        d90 = longint'(90) <<< (FRAC_BITS + 1);
        lat = (cu * ulat + cw * wlat + 4) >>> 3;
        if (ulon > d90 && wlon < -d90)
            wlon += longint'(360) <<< (FRAC_BITS + 1);
        else if (ulon < -d90 && wlon > d90)
            ulon += longint'(360) <<< (FRAC_BITS + 1);
        lon = (wrap_lon(cu * ulon + cw * wlon, FRAC_BITS + 3) + 4) >>> 3;
        f.row = row[8:0];
        f.col = col[11:0];
        f.lat = lat[29:0];
        f.lon = lon[28:0];
        f.last = 1'b0;
        expected_fine.push_back(f);
    endfunction

    // One half-step sample: blend with the row above, then store it.
    function automatic void half_step(int r, int rows, int s, longint lat, longint lon);
        longint ulat;
        longint ulon;
        lat = sx(lat, LINE_BITS);
        lon = sx(wrap_lon(lon, FRAC_BITS + 1), LINE_BITS);
        if (r > 0) begin
            ulat = half_lat[s];
            ulon = half_lon[s];
            if (r == 1) blend_fine(0, s, ulat, lat, ulon, lon, 5, -1);
            blend_fine(2 * r - 1, s, ulat, lat, ulon, lon, 3, 1);
            blend_fine(2 * r, s, ulat, lat, ulon, lon, 1, 3);
            if (r == rows - 1) blend_fine(2 * r + 1, s, ulat, lat, ulon, lon, -1, 5);
        end
        half_lat[s] = lat;
        half_lon[s] = lon;
    endfunction

    // Works out the fine samples that one coarse pixel completes.
    function automatic void predict_pixel(logic signed [27:0] a_in, logic signed [28:0] b_in);
        int     cols;
        int     rows;
        int     c;
        int     r;
        int     n0;
        longint a;
        longint b;
        longint p;
        longint q;
        longint d90;
        longint d360;
        longint mlon;
        longint elon;
        cols = cfg_cols < 2 ? 2 : (cfg_cols > MAX_COLS ? MAX_COLS : int'(cfg_cols));
        rows = cfg_rows < 2 ? 2 : int'(cfg_rows);
        a = a_in;
        b = b_in;
        p = last_lat;
        q = last_lon;
        d90 = longint'(90) <<< FRAC_BITS;
        d360 = longint'(360) <<< FRAC_BITS;
        c = pix_col >= cols ? 0 : pix_col;
        r = pix_row >= rows ? 0 : pix_row;
        n0 = expected_fine.size();
        if (c > 0) begin
            mlon = q + b;
            if ((q > d90 && b < -d90) || (q < -d90 && b > d90)) mlon += d360;
            half_step(r, rows, 2 * c - 2, 2 * p, 2 * q);
            half_step(r, rows, 2 * c - 1, p + a, mlon);
            if (c == cols - 1) begin
                if (b > d90 && q < -d90) elon = 3 * b - (q + d360);
                else if (b < -d90 && q > d90) elon = 3 * (b + d360) - q;
                else elon = 3 * b - q;
                half_step(r, rows, 2 * c, 2 * a, 2 * b);
                half_step(r, rows, 2 * c + 1, 3 * a - p, elon);
            end
        end
        last_lat = a;
        last_lon = b;
        if (c == cols - 1) begin
            c = 0;
            r++;
            if (r >= rows) r = 0;
        end else begin
            c++;
        end
        pix_col = c;
        pix_row = r;
        if (expected_fine.size() > n0)
            expected_fine[expected_fine.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Pixel driver: random gaps between requests.
    int s_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) predict_pixel(s_lat_in, s_lon_in);
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                s_lat_in <= pending_pixels[0].lat;
                s_lon_in <= pending_pixels[0].lon;
                void'(pending_pixels.pop_front());
                s_valid <= 1'b1;
                s_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random stalls and one long hold-off on request.
    int  m_stall = 0;
    bit  hold_done = 1'b0;
    always @(posedge aclk) begin
        fine_t f;
        if (aresetn && m_valid && m_ready) begin
            if (expected_fine.size() == 0) begin
                $display("%0t unexpected result row %0d col %0d", $realtime,
                         m_out_row_in_scan, m_out_col);
                mismatches++;
            end else begin
                f = expected_fine.pop_front();
                if (m_out_row_in_scan !== f.row) report_mismatch("row", m_out_row_in_scan, f.row);
                if (m_out_col !== f.col) report_mismatch("col", m_out_col, f.col);
                if (m_lat_out !== f.lat) report_mismatch("lat", m_lat_out, f.lat);
                if (m_lon_out !== f.lon) report_mismatch("lon", m_lon_out, f.lon);
                if (m_last !== f.last) report_mismatch("last", m_last, f.last);
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            m_stall <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (m_stall > 0) begin
            m_stall <= m_stall - 1;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready || !m_ready) begin
            if (m_ready && $urandom_range(0, 2) != 0) begin
                m_stall <= $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted request anywhere.
    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)
            || (m_stall > 0))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Waits until every pixel is taken and every result has come, then lets it settle.
    task automatic wait_drained();
        while (pending_pixels.size() > 0 || s_valid || s_gap > 0 || expected_fine.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(int index, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(index * 4);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == int'(REG_COL_COUNT)) cfg_cols = value[11:0];
        else cfg_rows = value[7:0];
        pix_col = 0;
        pix_row = 0;
    endtask

    task automatic set_grid(int cols, int rows);
        write_reg(int'(REG_COL_COUNT), cols);
        write_reg(int'(REG_SCAN_ROWS), rows);
    endtask

    task automatic add_pixel(longint lat, longint lon);
        pixel_t px;
        px.lat = lat[27:0];
        px.lon = lon[28:0];
        pending_pixels.push_back(px);
    endtask

    function automatic longint rand_lat();
        case ($urandom_range(0, 9))
            0: return sx(longint'($urandom()), 28);
            1: return $urandom_range(0, 1) ? LAT_MAX : -LAT_MAX;
            default: return longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
        endcase
    endfunction

    // Longitudes lean towards the date line so that straddling pairs are common.
    function automatic longint rand_lon();
        case ($urandom_range(0, 9))
            0: return sx(longint'($urandom()), 29);
            1, 2, 3: return LON_MAX - $urandom_range(0, 1 << 24);
            4, 5, 6: return -LON_MAX + $urandom_range(0, 1 << 24);
            default: return longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
        endcase
    endfunction

    task automatic random_pixels(int count);
        repeat (count) add_pixel(rand_lat(), rand_lon());
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Smallest grid: extremes, date-line straddles both ways, full-scale bit patterns.
        set_grid(2, 2);
        add_pixel(LAT_MAX, LON_MAX);
        add_pixel(-LAT_MAX, -LON_MAX);
        add_pixel(-LAT_MAX, -LON_MAX + 100);
        add_pixel(LAT_MAX, LON_MAX - 100);
        add_pixel(0, 120 <<< 20);
        add_pixel(0, -120 <<< 20);
        add_pixel(0, -120 <<< 20);
        add_pixel(0, 120 <<< 20);
        add_pixel(134217727, 268435455);
        add_pixel(-134217728, -268435456);
        add_pixel(-134217728, -268435456);
        add_pixel(134217727, 268435455);
        add_pixel(0, 0);
        add_pixel(-1, -1);
        add_pixel(1, 1);
        add_pixel(90 <<< 20, 90 <<< 20);
        wait_drained();

        // Out-of-range register values fall back to the smallest grid.
        set_grid(0, 1);
        random_pixels(9);
        wait_drained();

        // Largest sizes: a partial first row only, so no results.
        set_grid(4095, 255);
        random_pixels(10);
        wait_drained();
        set_grid(2048, 2);
        random_pixels(6);
        wait_drained();

        // Main random run with a long receiver hold-off in the middle.
        set_grid(5, 3);
        random_pixels(30);
        hold_req = 1'b1;
        random_pixels(25);
        wait_drained();

        // Mid-scan register write restarts the scan.
        set_grid(3, 255);
        random_pixels(15);
        wait_drained();
        write_reg(int'(REG_SCAN_ROWS), 4);
        random_pixels(20);
        wait_drained();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
